FILE: rtl/mtfr_pkg.sv
`default_nettype none

package mtfr_pkg;

  localparam int CH_W = 3;
  localparam int RD_W = 14;
  localparam int IT_W = 12;
  localparam int ST_W = 3;
  localparam int RT_W = 16;
  localparam int FR_W = 32;

  localparam logic [RT_W-1:0] RT_RESET    = 16'd100;
  localparam logic [RT_W-1:0] ELAPSED_MAX = 16'hFFFF;

  // converter frame layout
  localparam int RD_LSB  = 18;
  localparam int RD_MSB  = 31;
  localparam int FLT_BIT = 16;
  localparam int IT_LSB  = 4;
  localparam int IT_MSB  = 15;
  localparam int SCV_BIT = 2;
  localparam int SCG_BIT = 1;
  localparam int OC_BIT  = 0;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_STALE        = 3'd1,
    ST_FAULT        = 3'd2,
    ST_SHORT_SUPPLY = 3'd3,
    ST_SHORT_GROUND = 3'd4,
    ST_OPEN         = 3'd5
  } status_t;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef struct packed {
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    logic            wr_en;
    logic [CH_W-1:0] wr_addr;
    logic [RD_W-1:0] wr_data;
  } cache_req_t;

  // open beats short to ground beats short to supply beats generic fault
  function automatic status_t fault_code(input logic [FR_W-1:0] frame);
    status_t st;
    if (frame[OC_BIT]) begin
      st = ST_OPEN;
    end else if (frame[SCG_BIT]) begin
      st = ST_SHORT_GROUND;
    end else if (frame[SCV_BIT]) begin
      st = ST_SHORT_SUPPLY;
    end else if (frame[FLT_BIT]) begin
      st = ST_FAULT;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mtfr_cache.sv
`default_nettype none

module mtfr_cache #(
  parameter int CHANNELS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mtfr_pkg::cache_req_t     req,
  output logic [mtfr_pkg::RD_W-1:0]     rd_data
);
  import mtfr_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W:0] CH_LIM = (CH_W+1)'(CHANNELS);

  logic [RD_W-1:0]     mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [RD_W-1:0]     q_r;
  logic                qv_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (req.rd_en) begin
        qv_r <= vld_r[req.rd_addr[AW-1:0]];
      end
      if (req.wr_en) begin
        vld_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_data = qv_r ? q_r : '0;

`ifndef ASSERT_OFF
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> ({1'b0, req.wr_addr} < CH_LIM))
    else $error("cache write beyond channel count");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |-> ({1'b0, req.rd_addr} < CH_LIM))
    else $error("cache read beyond channel count");

  a_wr_marks: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |=> vld_r[$past(req.wr_addr[AW-1:0])])
    else $error("written entry not marked valid");
`endif

endmodule

`default_nettype wire

FILE: rtl/mux_thermocouple_frame_reader.sv
`default_nettype none

// channel  dir  handshake      payload
// in_      in   valid / stall  func, channel, frame
// out_     out  valid / stall  reading, internal_temp, status, mux_select, restarted
// cfg_     in   valid / ready  settle_ticks
//
// One transaction per cycle while in_stall is low; a read result appears in the cycle after acceptance.
// The per-channel cache is a one-port-read, one-port-write RAM read in the accept cycle.
// Tick transactions give no result. cfg_ready is always high.
// rst_n is synchronous; the cache reads as zero until each entry is written.
// in_stall is high only while a result sits in the output register and out_stall holds it.

module mux_thermocouple_frame_reader #(
  parameter int CHANNELS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_func,
  input  wire logic [mtfr_pkg::CH_W-1:0]         in_channel,
  input  wire logic [mtfr_pkg::FR_W-1:0]         in_frame,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [mtfr_pkg::RD_W-1:0]       out_reading,
  output logic signed [mtfr_pkg::IT_W-1:0]       out_internal_temp,
  output logic [mtfr_pkg::ST_W-1:0]              out_status,
  output logic [mtfr_pkg::CH_W-1:0]              out_mux_select,
  output logic                                   out_restarted,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mtfr_pkg::RT_W-1:0]         cfg_settle_ticks
);
  import mtfr_pkg::*;

  localparam logic [CH_W:0]   CH_LIM = (CH_W+1)'(CHANNELS);
  localparam logic [CH_W-1:0] CH_MAX = CH_W'(CHANNELS - 1);

  logic [RT_W-1:0] resp_r;
  logic [RT_W-1:0] elapsed_r, elapsed_nxt;
  logic [CH_W-1:0] act_ch_r, act_ch_nxt;
  logic            read_done_r, read_done_nxt;
  logic [IT_W-1:0] cached_int_r, cached_int_nxt;

  logic            out_valid_r;
  logic            stale_r;
  logic [RD_W-1:0] reading_r;
  logic [IT_W-1:0] int_r;
  status_t         status_r;
  logic [CH_W-1:0] mux_r;
  logic            restarted_r;

  logic            acc, rd_acc, tick_acc;
  logic [CH_W-1:0] ch_cl;
  logic            restart, fresh, ok;
  status_t         flt;
  cache_req_t      creq;
  logic [RD_W-1:0] cache_q;

  assign in_stall  = out_valid_r & out_stall;
  assign acc       = in_valid & ~in_stall;
  assign rd_acc    = acc & (func_t'(in_func) == FUNC_READ);
  assign tick_acc  = acc & (func_t'(in_func) == FUNC_TICK);
  assign cfg_ready = 1'b1;

  assign ch_cl   = ({1'b0, in_channel} >= CH_LIM) ? CH_MAX : in_channel;
  assign restart = read_done_r | (ch_cl != act_ch_r);
  // a restart zeroes the elapsed count, and the restarting read itself is always stale
  assign fresh   = ~restart & (elapsed_r > resp_r);
  assign flt     = fault_code(in_frame);
  assign ok      = fresh & (flt == ST_OK);

  always_comb begin
    elapsed_nxt    = elapsed_r;
    act_ch_nxt     = act_ch_r;
    read_done_nxt  = read_done_r;
    cached_int_nxt = cached_int_r;
    if (tick_acc && elapsed_r != ELAPSED_MAX) begin
      elapsed_nxt = elapsed_r + RT_W'(1);
    end
    if (rd_acc) begin
      read_done_nxt = ok;
      if (restart) begin
        elapsed_nxt = '0;
        act_ch_nxt  = ch_cl;
      end
      if (ok) begin
        cached_int_nxt = in_frame[IT_MSB:IT_LSB];
      end
    end
  end

  always_comb begin
    creq.rd_en   = rd_acc;
    creq.rd_addr = ch_cl;
    creq.wr_en   = rd_acc & ok;
    creq.wr_addr = ch_cl;
    creq.wr_data = in_frame[RD_MSB:RD_LSB];
  end

  mtfr_cache #(
    .CHANNELS (CHANNELS)
  ) u_cache (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (creq),
    .rd_data (cache_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_r       <= RT_RESET;
      elapsed_r    <= '0;
      act_ch_r     <= '0;
      read_done_r  <= 1'b0;
      cached_int_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        resp_r <= cfg_settle_ticks;
      end
      elapsed_r    <= elapsed_nxt;
      act_ch_r     <= act_ch_nxt;
      read_done_r  <= read_done_nxt;
      cached_int_r <= cached_int_nxt;
      if (rd_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      stale_r     <= ~fresh;
      status_r    <= fresh ? flt : ST_STALE;
      reading_r   <= ok ? in_frame[RD_MSB:RD_LSB] : '0;
      int_r       <= fresh ? (ok ? in_frame[IT_MSB:IT_LSB] : '0) : cached_int_r;
      mux_r       <= ch_cl;
      restarted_r <= restart;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reading       = stale_r ? cache_q : reading_r;
  assign out_internal_temp = int_r;
  assign out_status        = status_r;
  assign out_mux_select    = mux_r;
  assign out_restarted     = restarted_r;

`ifndef ASSERT_OFF
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_acc && restart) |=> (elapsed_r == '0))
    else $error("restart did not clear elapsed count");

  a_restart_stale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && restarted_r) |-> (status_r == ST_STALE))
    else $error("restarted read not reported stale");

  a_done_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(read_done_r) |-> $past(creq.wr_en))
    else $error("read marked done without cache update");

  a_mux_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rd_acc) |-> (mux_r == act_ch_r))
    else $error("reported mux select differs from active channel");
`endif

endmodule

`default_nettype wire

FILE: test/frame_reader_checker.sv
`timescale 1ns / 100ps

module frame_reader_checker #(
  parameter int CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_func,
  input  logic [mtfr_pkg::CH_W-1:0]          in_channel,
  input  logic [mtfr_pkg::FR_W-1:0]          in_frame,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [mtfr_pkg::RD_W-1:0]   out_reading,
  input  logic signed [mtfr_pkg::IT_W-1:0]   out_internal_temp,
  input  logic [mtfr_pkg::ST_W-1:0]          out_status,
  input  logic [mtfr_pkg::CH_W-1:0]          out_mux_select,
  input  logic                               out_restarted,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mtfr_pkg::RT_W-1:0]          cfg_settle_ticks,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked
);
  import mtfr_pkg::*;

  typedef struct packed {
    logic signed [RD_W-1:0] reading;
    logic signed [IT_W-1:0] internal_temp;
    status_t                status;
    logic [CH_W-1:0]        mux_select;
    logic                   restarted;
  } read_result_t;

  logic [RT_W-1:0] resp_time;
  logic [RT_W-1:0] elapsed;
  logic [CH_W-1:0] sel_ch;
  logic            done;
  logic [IT_W-1:0] cj_cache;
  logic [RD_W-1:0] tc_cache [CHANNELS];
  read_result_t    expected_reads [$];
  int              fails = 0;
  int              n_checked = 0;

  function automatic status_t frame_status(input logic [FR_W-1:0] f);
    casez ({f[OC_BIT], f[SCG_BIT], f[SCV_BIT], f[FLT_BIT]})
      4'b1???: frame_status = ST_OPEN;
      4'b01??: frame_status = ST_SHORT_GROUND;
      4'b001?: frame_status = ST_SHORT_SUPPLY;
      4'b0001: frame_status = ST_FAULT;
      default: frame_status = ST_OK;
    endcase
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  task automatic decode_read(input logic func, input logic [CH_W-1:0] ch_in,
                             input logic [FR_W-1:0] frame);
    logic [CH_W-1:0] ch;
    read_result_t    r;
    if (func == FUNC_TICK) begin
      if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
    end else begin
      ch = (ch_in >= CHANNELS) ? CH_W'(CHANNELS - 1) : ch_in;
      r.restarted = 1'b0;
      if (done || ch != sel_ch) begin
        sel_ch = ch;
        done = 1'b0;
        elapsed = '0;
        r.restarted = 1'b1;
      end
      r.mux_select = sel_ch;
      if (!done && elapsed <= resp_time) begin
        r.reading = tc_cache[sel_ch];
        r.internal_temp = cj_cache;
        r.status = ST_STALE;
      end else begin
        r.status = frame_status(frame);
        if (r.status != ST_OK) begin
          r.reading = '0;
          r.internal_temp = '0;
        end else begin
          r.reading = frame[RD_MSB:RD_LSB];
          r.internal_temp = frame[IT_MSB:IT_LSB];
          cj_cache = frame[IT_MSB:IT_LSB];
          tc_cache[sel_ch] = frame[RD_MSB:RD_LSB];
          done = 1'b1;
        end
      end
      expected_reads.push_back(r);
    end
  endtask

  task automatic check_result();
    read_result_t w;
    if (expected_reads.size() == 0) begin
      report("result with nothing outstanding, status", int'(out_status), -1);
    end else begin
      w = expected_reads.pop_front();
      n_checked++;
      if (out_reading !== w.reading)
        report("reading", int'(out_reading), int'($signed(w.reading)));
      if (out_internal_temp !== w.internal_temp)
        report("internal_temp", int'(out_internal_temp), int'($signed(w.internal_temp)));
      if (out_status !== w.status)
        report("status", int'(out_status), int'(w.status));
      if (out_mux_select !== w.mux_select)
        report("mux_select", int'(out_mux_select), int'(w.mux_select));
      if (out_restarted !== w.restarted)
        report("restarted", int'(out_restarted), int'(w.restarted));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      resp_time = RT_RESET;
      elapsed = '0;
      sel_ch = '0;
      done = 1'b0;
      cj_cache = '0;
      foreach (tc_cache[i]) tc_cache[i] = '0;
      expected_reads.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) resp_time = cfg_settle_ticks;
      if (in_valid && !in_stall) decode_read(in_func, in_channel, in_frame);
    end
    pending <= expected_reads.size();
    fail_count <= fails;
    checked <= n_checked;
  end

endmodule

FILE: test/tb_mux_thermocouple_frame_reader.sv
`timescale 1ns / 100ps

module tb_mux_thermocouple_frame_reader;
  import mtfr_pkg::*;

  localparam logic [3:0] FL_NONE = 4'b0000;
  localparam logic [3:0] FL_OPEN = 4'b1000;
  localparam logic [3:0] FL_GND  = 4'b0100;
  localparam logic [3:0] FL_SUP  = 4'b0010;
  localparam logic [3:0] FL_GEN  = 4'b0001;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_func;
  logic [CH_W-1:0]        in_channel;
  logic [FR_W-1:0]        in_frame;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [RD_W-1:0] out_reading;
  logic signed [IT_W-1:0] out_internal_temp;
  logic [ST_W-1:0]        out_status;
  logic [CH_W-1:0]        out_mux_select;
  logic                   out_restarted;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [RT_W-1:0]        cfg_settle_ticks;

  int fail_count;
  int pending;
  int checked;
  int n_reads = 0;
  int n_ticks = 0;
  int n_settings = 0;
  bit idle_on = 1'b1;
  bit hold_long = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mux_thermocouple_frame_reader #(.CHANNELS(8)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_channel        (in_channel),
    .in_frame          (in_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reading       (out_reading),
    .out_internal_temp (out_internal_temp),
    .out_status        (out_status),
    .out_mux_select    (out_mux_select),
    .out_restarted     (out_restarted),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_settle_ticks  (cfg_settle_ticks)
  );

  frame_reader_checker #(.CHANNELS(8)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_channel        (in_channel),
    .in_frame          (in_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reading       (out_reading),
    .out_internal_temp (out_internal_temp),
    .out_status        (out_status),
    .out_mux_select    (out_mux_select),
    .out_restarted     (out_restarted),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_settle_ticks  (cfg_settle_ticks),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  function automatic logic [FR_W-1:0] mk_frame(input logic [RD_W-1:0] rd,
                                               input logic [IT_W-1:0] it,
                                               input logic [3:0] flags);
    logic [FR_W-1:0] f;
    f = '0;
    f[RD_MSB:RD_LSB] = rd;
    f[IT_MSB:IT_LSB] = it;
    {f[OC_BIT], f[SCG_BIT], f[SCV_BIT], f[FLT_BIT]} = flags;
    return f;
  endfunction

  // mostly clean frames; the rest carry random fault bits
  function automatic logic [FR_W-1:0] rand_frame();
    logic [FR_W-1:0] f;
    f = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      f[OC_BIT] = 1'b0;
      f[SCG_BIT] = 1'b0;
      f[SCV_BIT] = 1'b0;
      f[FLT_BIT] = 1'b0;
    end
    return f;
  endfunction

  task automatic send_item(input func_t f, input logic [CH_W-1:0] ch,
                           input logic [FR_W-1:0] fr);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_channel <= ch;
    in_frame <= fr;
    do @(posedge clk); while (in_stall);
    if (f == FUNC_READ) n_reads++;
    else n_ticks++;
  endtask

  task automatic tick_items(input int n);
    for (int i = 0; i < n; i++) send_item(FUNC_TICK, CH_W'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic read_item(input logic [CH_W-1:0] ch, input logic [FR_W-1:0] fr);
    send_item(FUNC_READ, ch, fr);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_settle_ticks(input logic [RT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_settle_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        hold = 60;
      end else begin
        hold = idle_on ? $urandom_range(0, 14) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [CH_W-1:0] ch;
    logic [RT_W-1:0] rt;
    int start;
    int wait_cycles;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_TICK;
    in_channel <= '0;
    in_frame <= '0;
    cfg_valid <= 1'b0;
    cfg_settle_ticks <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: fresh only once more than 100 ticks have passed
    read_item(3'd0, mk_frame(14'd100, 12'd25, FL_NONE));
    tick_items(100);
    read_item(3'd0, mk_frame(14'd100, 12'd25, FL_NONE));
    tick_items(1);
    read_item(3'd0, mk_frame(14'd100, 12'd25, FL_NONE));
    wait_idle();

    set_settle_ticks('0);
    read_item(3'd1, mk_frame(14'h1FFF, 12'h7FF, FL_NONE));
    tick_items(1);
    read_item(3'd1, mk_frame(14'h1FFF, 12'h7FF, FL_NONE));
    read_item(3'd1, mk_frame(14'h2000, 12'h800, FL_NONE));
    tick_items(1);
    read_item(3'd1, mk_frame(14'h2000, 12'h800, FL_NONE));
    read_item(3'd2, mk_frame(14'h3FFF, 12'hFFF, FL_NONE));
    tick_items(1);
    read_item(3'd2, mk_frame(14'h3FFF, 12'hFFF, FL_NONE));
    read_item(3'd3, '1);
    tick_items(1);
    read_item(3'd3, mk_frame(14'h1234, 12'h321, FL_OPEN));
    read_item(3'd3, mk_frame(14'h1234, 12'h321, FL_GND));
    read_item(3'd3, mk_frame(14'h1234, 12'h321, FL_SUP));
    read_item(3'd3, mk_frame(14'h1234, 12'h321, FL_GEN));
    read_item(3'd3, '1);
    read_item(3'd3, mk_frame(14'h1234, 12'h321, FL_GND | FL_SUP | FL_GEN));
    read_item(3'd3, mk_frame(14'h1234, 12'h321, FL_SUP | FL_GEN));
    read_item(3'd3, mk_frame('0, '0, FL_NONE));
    for (int c = 4; c < 8; c++) read_item(CH_W'(c), mk_frame(RD_W'(c * 1000), IT_W'(-c), FL_NONE));
    wait_idle();

    // never ready at the top setting
    set_settle_ticks(16'hFFFF);
    read_item(3'd3, mk_frame(14'h0ABC, 12'h0DE, FL_NONE));
    idle_on = 1'b0;
    tick_items(40);
    idle_on = 1'b1;
    read_item(3'd3, mk_frame(14'h0ABC, 12'h0DE, FL_NONE));
    wait_idle();
    set_settle_ticks(16'hFFFE);
    read_item(3'd3, mk_frame(14'h0ABC, 12'h0DE, FL_NONE));
    wait_idle();

    ch = '0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: rt = '0;
        1: rt = 16'd1;
        default: rt = RT_W'($urandom_range(0, 6));
      endcase
      set_settle_ticks(rt);
      idle_on = (ph != 2);
      hold_long = (ph == 2);
      start = n_reads + n_ticks;
      while (n_reads + n_ticks - start < 140) begin
        if ($urandom_range(0, 6) == 0) begin
          send_item(func_t'($urandom_range(0, 1)), CH_W'($urandom_range(0, 7)), $urandom);
        end else begin
          if ($urandom_range(0, 2) == 0) ch = CH_W'($urandom_range(0, 7));
          read_item(ch, rand_frame());
          tick_items($urandom_range(0, int'(rt) + 2));
          repeat ($urandom_range(1, 3)) read_item(ch, rand_frame());
        end
      end
      idle_on = 1'b1;
      wait_idle();
    end

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (5) @(posedge clk);
    $display("tb: %0d reads and %0d ticks sent under %0d settle-time settings,",
             n_reads, n_ticks, n_settings);
    $display("tb: %0d read results compared, incl. fault priority and top settings",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
